>>> hw/rtl/rbf_pkg.sv
// ---------------------------------------------------------------------------
// rbf_pkg
// Shared types, constants and helpers for the ring buffer FIFO unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbf_pkg;

  // store geometry
  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 64;
  localparam int SIZE_W    = $clog2(DEPTH) + 1;
  localparam int CNT_W     = $clog2(DEPTH);
  // one slot always stays reserved, so the last store slot is never occupied
  localparam int NUM_CELLS = DEPTH - 1;

  // request actions
  typedef enum logic [1:0] {
    ACT_PUT    = 2'd0,
    ACT_GET    = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_STATUS = 2'd3
  } act_t;

  // configuration register indexes
  typedef enum logic {
    REG_SIZE = 1'b0,
    REG_WLEN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    act_t                 action;
    logic [WORD_BITS-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [WORD_BITS-1:0] read_data;
    logic [7:0]           used_count;
    logic [7:0]           free_count;
    logic                 is_empty;
    logic                 is_full;
  } resp_t;

  // per-cycle control for the cell chain
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [CNT_W-1:0] load_slot;
  } cell_ctl_t;

  // word mask for a word length mode, limited to the store width
  function automatic logic [WORD_BITS-1:0] word_mask(input logic [1:0] mode);
    logic [WORD_BITS-1:0] m;
    int                   bits;
    bits = 8 << mode;
    for (int b = 0; b < WORD_BITS; b++) begin
      m[b] = (b < bits);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rbf_cell.sv
// ---------------------------------------------------------------------------
// rbf_cell
// One word slot of the chain: loads a new word when addressed by a put and
// takes its upper neighbor's word when the head is popped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbf_cell (
  input  wire logic                         clk,
  input  wire rbf_pkg::cell_ctl_t           ctl,
  input  wire logic [rbf_pkg::CNT_W-1:0]    slot_id,
  input  wire logic [rbf_pkg::WORD_BITS-1:0] put_word,
  input  wire logic [rbf_pkg::WORD_BITS-1:0] up_word,
  output logic      [rbf_pkg::WORD_BITS-1:0] word
);
  import rbf_pkg::*;

  // load on put to this slot, shift toward the head on get
  always_ff @(posedge clk) begin
    if (ctl.load && (ctl.load_slot == slot_id)) begin
      word <= put_word;
    end else if (ctl.shift) begin
      word <= up_word;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rbf_ctrl.sv
// ---------------------------------------------------------------------------
// rbf_ctrl
// Fill count, configuration, request decode and the registered response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbf_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire rbf_pkg::req_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output rbf_pkg::resp_t                     out_data,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [rbf_pkg::SIZE_W-1:0]    cfg_data,
  input  wire logic [rbf_pkg::WORD_BITS-1:0] head_word,
  output rbf_pkg::cell_ctl_t                 cell_ctl,
  output logic      [rbf_pkg::WORD_BITS-1:0] put_word
);
  import rbf_pkg::*;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W-1:0]     cap;
  logic [CNT_W-1:0]     cap_next;
  logic [1:0]           wlen;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [WORD_BITS-1:0] mask;
  resp_t                resp_next;
  reg_idx_t             cfg_reg;

  assign cfg_reg  = reg_idx_t'(cfg_index);
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == cap);
  assign empty    = (count == '0);
  assign mask     = word_mask(wlen);
  assign put_word = in_data.write_data & mask;

  // capacity is the effective size minus the reserved slot
  always_comb begin
    if (cfg_data == '0) begin
      cap_next = '0;
    end else if (cfg_data > SIZE_W'(DEPTH)) begin
      cap_next = CNT_W'(DEPTH - 1);
    end else begin
      cap_next = CNT_W'(cfg_data - SIZE_W'(1));
    end
  end

  // request decode
  always_comb begin
    count_next          = count;
    cell_ctl.shift      = 1'b0;
    cell_ctl.load       = 1'b0;
    cell_ctl.load_slot  = count;
    resp_next.ok        = 1'b1;
    resp_next.read_data = '0;
    case (in_data.action)
      ACT_PUT: begin
        if (full) begin
          resp_next.ok = 1'b0;
        end else begin
          cell_ctl.load = accept;
          count_next    = count + CNT_W'(1);
        end
      end
      ACT_GET: begin
        if (empty) begin
          resp_next.ok = 1'b0;
        end else begin
          cell_ctl.shift      = accept;
          resp_next.read_data = head_word & mask;
          count_next          = count - CNT_W'(1);
        end
      end
      ACT_FLUSH: count_next = '0;
      default:   count_next = count;
    endcase
    resp_next.used_count = 8'(count_next);
    resp_next.free_count = 8'(cap - count_next);
    resp_next.is_empty   = (count_next == '0);
    resp_next.is_full    = (count_next == cap);
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= CNT_W'(DEPTH - 1);
      wlen  <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_reg)
        REG_SIZE: begin
          cap   <= cap_next;
          count <= '0;
        end
        REG_WLEN: wlen <= cfg_data[1:0];
        default:  wlen <= wlen;
      endcase
    end else if (accept) begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= resp_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ring_buffer_fifo_unit.sv
// ---------------------------------------------------------------------------
// ring_buffer_fifo_unit
// FIFO with configurable size and word length, built as a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_stall/in_data): one request per transfer,
//     action put, get, flush or status, with the word to store on put.
//   out channel (out_valid/out_stall/out_data): one response per request,
//     giving ok, read data, used and free counts, empty and full.
//   cfg port: cfg_we with cfg_index 0 sets the size in use (also empties
//     the buffer), index 1 sets the word length; write only while idle.
// Response: registered, it appears in the cycle after the request is taken.
// Throughput: one request per cycle while no stalled response is pending; the fill count update and the cell
//   chain shift both complete in the cycle the request is taken.
// Storage: the head word always sits in cell 0; a get shifts every cell
//   down by one, a put loads the cell at the fill count.
// Reset: fill count cleared, size set to the full store, one-byte words.
// Stall: while out_stall holds a pending response, in_stall is raised and
//   the response stays on out_data unchanged.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_fifo_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire rbf_pkg::req_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output rbf_pkg::resp_t                  out_data,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [rbf_pkg::SIZE_W-1:0] cfg_data
);
  import rbf_pkg::*;

  cell_ctl_t            cell_ctl;
  logic [WORD_BITS-1:0] put_word;
  logic [WORD_BITS-1:0] cell_word [NUM_CELLS];

  // control and response
  rbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head_word (cell_word[0]),
    .cell_ctl  (cell_ctl),
    .put_word  (put_word)
  );

  // cell chain, head at cell 0
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [WORD_BITS-1:0] up_word;
    if (i == NUM_CELLS - 1) begin : g_last
      assign up_word = '0;
    end else begin : g_mid
      assign up_word = cell_word[i+1];
    end
    rbf_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .slot_id  (CNT_W'(i)),
      .put_word (put_word),
      .up_word  (up_word),
      .word     (cell_word[i])
    );
  end

endmodule

`default_nettype wire

>>> hw/rtl/rbf_checker.sv
// ---------------------------------------------------------------------------
// rbf_checker
// Port-level checks for the ring buffer FIFO unit, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbf_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire rbf_pkg::req_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire rbf_pkg::resp_t out_data
);
  import rbf_pkg::*;

  // stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled response changed");

  // empty response reports no words held
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_empty) |-> (out_data.used_count == 8'd0))
    else $error("empty with nonzero used count");

  // full response reports no free slots
  a_full_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_full) |-> (out_data.free_count == 8'd0))
    else $error("full with nonzero free count");

  // a flush request yields an empty, successful response next cycle
  a_flush: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.action == ACT_FLUSH)
      |=> (out_valid && out_data.is_empty && out_data.ok))
    else $error("flush did not empty the buffer");

  // no response right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("response valid after reset");

endmodule

bind ring_buffer_fifo_unit rbf_checker u_rbf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

>>> tb/sv/rbf_resp_checker.sv
// ---------------------------------------------------------------------------
// rbf_resp_checker
// Watches the request, response and register ports of the ring buffer FIFO,
// keeps its own copy of the ring (store, positions, size and word length),
// works out the response of every accepted request and compares it field by
// field with what the unit returns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbf_resp_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  rbf_pkg::req_t              in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  rbf_pkg::resp_t             out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [rbf_pkg::SIZE_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         outstanding
);
  import rbf_pkg::*;

  // ring copy
  logic [WORD_BITS-1:0] ring_words [DEPTH];
  int unsigned          head_pos;
  int unsigned          tail_pos;
  logic [SIZE_W-1:0]    size_reg;
  logic [1:0]           wlen_reg;

  resp_t awaited_resps [$];
  int    mismatch_total = 0;

  assign fail_count = mismatch_total;

  function automatic int unsigned bump_pos(input int unsigned pos, input int unsigned slots);
    return (pos + 1 >= slots) ? 0 : pos + 1;
  endfunction

  // full when the tail is one slot behind the head
  function automatic bit ring_full(input int unsigned slots);
    return bump_pos(tail_pos, slots) == head_pos;
  endfunction

  // apply one request to the ring copy and form the response it gives
  task automatic advance_ring(input req_t r, output resp_t p);
    int unsigned          slots;
    int unsigned          used;
    int                   bits;
    logic [WORD_BITS-1:0] mask;
    slots = (size_reg == 0) ? 1 : (size_reg > DEPTH) ? DEPTH : size_reg;
    bits  = 8 << wlen_reg;
    mask  = (bits >= WORD_BITS) ? '1 : (64'd1 << bits) - 64'd1;
    p     = '0;
    p.ok  = 1'b1;
    case (r.action)
      ACT_PUT: begin
        if (ring_full(slots)) begin
          p.ok = 1'b0;
        end else begin
          ring_words[tail_pos] = r.write_data & mask;
          tail_pos = bump_pos(tail_pos, slots);
        end
      end
      ACT_GET: begin
        if (head_pos == tail_pos) begin
          p.ok = 1'b0;
        end else begin
          p.read_data = ring_words[head_pos] & mask;
          head_pos = bump_pos(head_pos, slots);
        end
      end
      ACT_FLUSH: begin
        head_pos = 0;
        tail_pos = 0;
      end
      default: ;
    endcase
    used = (tail_pos >= head_pos) ? tail_pos - head_pos : slots - (head_pos - tail_pos);
    p.used_count = 8'(used);
    p.free_count = 8'(slots - 1 - used);
    p.is_empty   = (head_pos == tail_pos);
    p.is_full    = ring_full(slots);
  endtask

  task automatic compare_field(input string name, input logic [WORD_BITS-1:0] want,
                               input logic [WORD_BITS-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    resp_t want;
    if (rst) begin
      head_pos = 0;
      tail_pos = 0;
      size_reg = SIZE_W'(DEPTH);
      wlen_reg = 2'd0;
      awaited_resps.delete();
    end else begin
      // response side
      if (out_valid && !out_stall) begin
        if (awaited_resps.size() == 0) begin
          $error("response with no request outstanding");
          mismatch_total++;
        end else begin
          want = awaited_resps.pop_front();
          compare_field("ok", want.ok, out_data.ok);
          compare_field("read_data", want.read_data, out_data.read_data);
          compare_field("used_count", want.used_count, out_data.used_count);
          compare_field("free_count", want.free_count, out_data.free_count);
          compare_field("is_empty", want.is_empty, out_data.is_empty);
          compare_field("is_full", want.is_full, out_data.is_full);
        end
      end
      // register writes; a size write also empties the ring
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_SIZE: begin
            size_reg = cfg_data;
            head_pos = 0;
            tail_pos = 0;
          end
          REG_WLEN: wlen_reg = cfg_data[1:0];
          default: ;
        endcase
      end
      // request side
      if (in_valid && !in_stall) begin
        advance_ring(in_data, want);
        awaited_resps.push_back(want);
      end
    end
    outstanding = awaited_resps.size();
  end

endmodule

>>> tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Top of the ring buffer FIFO bench: drives requests, random response stalls
// and register writes across several ring sizes and word lengths, and gives
// the verdict from the failure count of the response checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rbf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  req_t              in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  resp_t             out_data;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  bit calm = 1'b0;

  always #10 clk = ~clk;

  ring_buffer_fifo_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rbf_resp_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // consumer stalls at random, never during the calm stretch
  always @(posedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < 37);
  end

  // one request, with random idle cycles ahead of it
  task automatic send(input act_t a, input logic [WORD_BITS-1:0] d);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req_t'{a, d};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold requests until every response is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [SIZE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [SIZE_W-1:0] size, input logic [1:0] mode);
    settle();
    write_reg(REG_SIZE, size);
    write_reg(REG_WLEN, SIZE_W'(mode));
  endtask

  // random requests with the given put and get shares in percent
  task automatic random_run(input int n, input int put_pct, input int get_pct);
    int                   r;
    int                   rest;
    act_t                 a;
    logic [WORD_BITS-1:0] d;
    rest = 100 - put_pct - get_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < put_pct) a = ACT_PUT;
      else if (r < put_pct + get_pct) a = ACT_GET;
      else if (r < put_pct + get_pct + rest / 3) a = ACT_FLUSH;
      else a = ACT_STATUS;
      case ($urandom_range(9))
        0: d = '0;
        1: d = '1;
        default: d = {$urandom, $urandom};
      endcase
      send(a, d);
    end
  endtask

  // watchdog
  initial begin : watchdog
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] sz;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state is 256 slots, one-byte words
    send(ACT_STATUS, '0);
    send(ACT_GET, '0);
    send(ACT_PUT, '1);
    send(ACT_PUT, 64'h0123_4567_89ab_cdef);
    send(ACT_GET, '0);
    send(ACT_FLUSH, '1);
    send(ACT_GET, '0);
    send(ACT_PUT, '0);

    // two slots: a single word fills the ring
    reconfigure(SIZE_W'(2), 2'd3);
    send(ACT_PUT, '1);
    send(ACT_PUT, 64'h5);
    send(ACT_STATUS, '0);
    send(ACT_GET, '0);
    send(ACT_GET, '0);

    // one slot: empty and full at once, every put and get refused
    reconfigure(SIZE_W'(1), 2'd2);
    send(ACT_PUT, '1);
    send(ACT_GET, '0);
    send(ACT_STATUS, '0);

    // zero acts as one slot
    reconfigure('0, 2'd1);
    send(ACT_PUT, '1);
    send(ACT_FLUSH, '0);

    // size above the store acts as the full store
    reconfigure('1, 2'd3);
    send(ACT_PUT, '1);
    send(ACT_PUT, 64'ha5a5_5a5a_f00f_0ff0);

    // word length shrunk while words are held: masked on the way out
    settle();
    write_reg(REG_WLEN, SIZE_W'(0));
    send(ACT_GET, '0);
    send(ACT_GET, '0);

    // full store: fill past full, then shorten words and drain past empty
    reconfigure(SIZE_W'(DEPTH), 2'd3);
    random_run(600, 75, 20);
    settle();
    write_reg(REG_WLEN, SIZE_W'(2));
    random_run(300, 15, 80);

    // long stretch with no idling on either side
    reconfigure('1, 2'd1);
    calm = 1'b1;
    random_run(150, 45, 40);
    settle();
    calm = 1'b0;

    reconfigure(SIZE_W'(2), 2'd0);
    random_run(50, 45, 40);
    reconfigure(SIZE_W'(3), 2'd2);
    random_run(150, 45, 40);
    reconfigure(SIZE_W'(1), 2'd0);
    random_run(30, 40, 40);
    reconfigure('0, 2'd3);
    random_run(20, 40, 40);

    for (int k = 0; k < 4; k++) begin
      sz = ($urandom_range(1) == 0) ? SIZE_W'($urandom_range(2, 16))
                                    : SIZE_W'($urandom_range(0, 511));
      reconfigure(sz, 2'($urandom_range(3)));
      random_run(60, 50, 40);
    end

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
